// ===== src/omni_drive_ramp_mix_packetizer_defines.svh =====
// Assertion macros used by the checker file of the drive mixer.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef OMNI_DRIVE_RAMP_MIX_PACKETIZER_DEFINES_SVH
`define OMNI_DRIVE_RAMP_MIX_PACKETIZER_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent
`define ODRMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define ODRMP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== src/odrmp_pkg.sv =====
// Shared types and constants for the mecanum drive mixer and packetizer.
// No dependencies; imported by the divider, serializer and top level.
package odrmp_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_MAX_SPEED  = 2'd0;
  localparam logic [1:0] CFG_RAMP_UP    = 2'd1;
  localparam logic [1:0] CFG_RAMP_DOWN  = 2'd2;

  // Configuration reset values
  localparam logic [6:0]  MAX_SPEED_RST = 7'd127;
  localparam logic [15:0] RAMP_UP_RST   = 16'd500;
  localparam logic [15:0] RAMP_DOWN_RST = 16'd250;

  // Packet fields
  localparam logic [7:0] FRONT_ADDR = 8'd128;
  localparam logic [7:0] BACK_ADDR  = 8'd129;
  localparam logic [7:0] MOTOR2_CMD = 8'd4;
  localparam logic [7:0] CHECK_MASK = 8'h7F;

  // Ramp step saturation
  localparam logic [15:0] STEP_MAX = 16'hFFFF;

  // Run of bytes per tick
  localparam int unsigned RUN_BYTES = 16;
  localparam logic [3:0]  LAST_BYTE_IDX = 4'(RUN_BYTES - 1);

  // Request from the sequencer to the serializer: four packet powers,
  // already signed as they go on the wire (back wheels inverted)
  typedef struct packed {
    logic            load;
    logic [3:0][7:0] power;
  } pkt_req_t;

endpackage

// ===== src/odrmp_div.sv =====
// Iterative restoring divider for the ramp step: elapsed*32768/ms, saturated.
// One quotient bit per cycle; depends on odrmp_pkg.
module odrmp_div
  import odrmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quot
);

  logic        busy_r;
  logic        sat_r;
  logic        done_r;
  logic [3:0]  cnt_r;
  logic [15:0] rem_r;
  logic [15:0] num_r;
  logic [15:0] den_r;
  logic [15:0] quot_r;

  logic [16:0] trial;
  logic [16:0] diff;
  logic        fits;
  logic        sat_nxt;

  // Trial subtract of the shifted remainder
  assign trial   = {rem_r, num_r[15]};
  assign diff    = trial - {1'b0, den_r};
  assign fits    = (trial >= {1'b0, den_r});
  // Quotient reaches 65536 when the dividend shifted right by one is not below ms
  assign sat_nxt = ({1'b0, dividend[15:1]} >= divisor);

  // Control: run sixteen steps or finish at once on saturation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      sat_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        sat_r  <= sat_nxt;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (sat_r || (cnt_r == 4'd15)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder, dividend shift and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, dividend[15:1]};
      num_r  <= {dividend[0], 15'd0};
      den_r  <= divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      if (sat_r) begin
        quot_r <= STEP_MAX;
      end else begin
        rem_r  <= fits ? diff[15:0] : trial[15:0];
        num_r  <= {num_r[14:0], 1'b0};
        quot_r <= {quot_r[14:0], fits};
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// ===== src/odrmp_ser.sv =====
// Packet serializer: turns four wheel powers into sixteen bytes with checksums.
// Holds its own copy of the powers and an output register; uses odrmp_pkg.
module odrmp_ser
  import odrmp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  pkt_req_t req,
  output logic     ready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output logic [7:0] out_tdata,  // [7:0] tx_byte
  output logic     out_tlast     // last_byte
);

  logic            active_r;
  logic [3:0]      cnt_r;
  logic [3:0][7:0] pwr_r;
  logic            ov_r;
  logic [7:0]      od_r;
  logic            ol_r;

  logic       adv;
  logic [1:0] pkt;
  logic [7:0] p;
  logic       neg;
  logic [7:0] mag;
  logic [7:0] addr;
  logic [7:0] cmd;
  logic [7:0] sum8;
  logic [7:0] byte_nxt;

  // Advance when a byte is pending and the output slot frees up
  assign adv = active_r && (!ov_r || out_tready);

  // Build the current byte of the run
  always_comb begin
    pkt  = cnt_r[3:2];
    p    = pwr_r[pkt];
    neg  = p[7];
    mag  = neg ? (8'd0 - p) : p;
    addr = pkt[1] ? FRONT_ADDR : BACK_ADDR;
    cmd  = (pkt[0] ? MOTOR2_CMD : 8'd0) + {7'd0, neg};
    sum8 = addr + cmd + mag;
    unique case (cnt_r[1:0])
      2'd0: byte_nxt = addr;
      2'd1: byte_nxt = cmd;
      2'd2: byte_nxt = mag;
      2'd3: byte_nxt = sum8 & CHECK_MASK;
      default: byte_nxt = addr;
    endcase
  end

  // Control: run counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (req.load) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (adv) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == LAST_BYTE_IDX) begin
          active_r <= 1'b0;
        end
      end
      if (adv) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Payload: captured powers and the output byte
  always_ff @(posedge clk) begin
    if (req.load) begin
      pwr_r <= req.power;
    end
    if (adv) begin
      od_r <= byte_nxt;
      ol_r <= (cnt_r == LAST_BYTE_IDX);
    end
  end

  assign ready      = !active_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

endmodule

// ===== src/omni_drive_ramp_mix_packetizer.sv =====
// Top level of the mecanum drive mixer with slew limit and packet serializer.
// Holds the sequencer, config registers and shared multiplier; uses odrmp_pkg,
// odrmp_div and odrmp_ser.
//
//   channel  direction  handshake                   payload
//   in_      slave      in_tvalid / in_tready       in_tdata (axes, speed, ms), in_tuser
//   out_     master     out_tvalid / out_tready     out_tdata (byte), out_tlast
//   cfg_     slave      cfg_valid / cfg_ready       cfg_index, cfg_data
//
// A request runs two ramp step divisions in the shared divider (one quotient bit
// per cycle), then each axis and then each wheel in turn through the one shared
// multiplier, and then the hand-off to the serializer.
// The sixteen output bytes stream from the serializer while the next request is
// being worked on; out_tready low stalls the serializer and then the hand-off.
// rst_n is synchronous, active low; it restores the config defaults and clears
// the ramped axes. cfg_ready is always high.
module omni_drive_ramp_mix_packetizer
  import odrmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] axis_x, [31:16] axis_y, [47:32] axis_rotation,
  // [62:48] speed_scale, [78:63] elapsed_ms, [79] zero
  input  logic [79:0] in_tdata,
  input  logic        in_tuser,   // [0] motors_enabled
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] tx_byte
  output logic        out_tlast,  // last_byte
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_AXIS  = 5'b00100,
    S_WHEEL = 5'b01000,
    S_HAND  = 5'b10000
  } state_t;

  state_t state_r;

  // Configuration
  logic [6:0]  max_speed_r;
  logic [15:0] ramp_up_r;
  logic [15:0] ramp_down_r;

  // Request registers
  logic signed [15:0] axin_r [3];
  logic [14:0]        speed_r;
  logic [15:0]        elapsed_r;
  logic               en_r;
  logic [15:0]        up_r;
  logic [15:0]        down_r;

  // Ramp state and working registers
  logic signed [15:0] axes_r [3];
  logic signed [33:0] prod_r;
  logic [3:0][7:0]    pwr_r;
  logic [1:0]         cnt_r;
  logic               phase_r;
  logic               div_sel_r;

  logic        accept;
  logic        div_start;
  logic [15:0] div_dividend;
  logic [15:0] div_divisor;
  logic        div_done;
  logic [15:0] div_quot;
  pkt_req_t    ser_req;
  logic        ser_ready;

  logic signed [17:0] mul_a;
  logic [14:0]        mul_b;
  logic signed [33:0] prod;
  logic signed [33:0] adj;
  logic signed [15:0] axis_sel;
  logic signed [15:0] cur;
  logic signed [17:0] ax18;
  logic signed [17:0] ay18;
  logic signed [17:0] ar18;
  logic signed [17:0] wsum;

  logic signed [17:0] c18;
  logic signed [17:0] t18;
  logic signed [17:0] s18;
  logic signed [17:0] n_up;
  logic signed [17:0] n_dn;
  logic signed [17:0] moved;
  logic               faster;

  logic signed [9:0] q10;
  logic signed [9:0] lim10;
  logic signed [9:0] clamped;
  logic signed [9:0] gated;
  logic signed [9:0] pk;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // Divider launch: up step on accept, down step after the up step lands
  assign div_start    = accept || ((state_r == S_DIV) && div_done && !div_sel_r);
  assign div_dividend = accept ? in_tdata[78:63] : elapsed_r;
  assign div_divisor  = accept ? ramp_up_r : ramp_down_r;

  odrmp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  // Pick the axis and wheel sum for the current step
  assign ax18 = {{2{axes_r[0][15]}}, axes_r[0]};
  assign ay18 = {{2{axes_r[1][15]}}, axes_r[1]};
  assign ar18 = {{2{axes_r[2][15]}}, axes_r[2]};

  always_comb begin
    unique case (cnt_r)
      2'd0: begin
        axis_sel = axin_r[0];
        cur      = axes_r[0];
        wsum     = ay18 - ax18 - ar18;  // back left
      end
      2'd1: begin
        axis_sel = axin_r[1];
        cur      = axes_r[1];
        wsum     = ay18 + ax18 + ar18;  // back right
      end
      2'd2: begin
        axis_sel = axin_r[2];
        cur      = axes_r[2];
        wsum     = ay18 - ax18 + ar18;  // front right
      end
      default: begin
        axis_sel = axin_r[2];
        cur      = axes_r[2];
        wsum     = ay18 + ax18 - ar18;  // front left
      end
    endcase
  end

  // Shared multiplier: axis times speed, or wheel sum times max speed
  always_comb begin
    if (state_r == S_AXIS) begin
      mul_a = {{2{axis_sel[15]}}, axis_sel};
      mul_b = speed_r;
    end else begin
      mul_a = wsum;
      mul_b = {8'd0, max_speed_r};
    end
    prod = mul_a * $signed({1'b0, mul_b});
  end

  // Divide the product by 32768, truncating toward zero
  assign adj = prod_r + (prod_r[33] ? 34'sd32767 : 34'sd0);

  // Move the ramped axis toward its target without passing it
  always_comb begin
    c18    = {{2{cur[15]}}, cur};
    t18    = {{2{adj[30]}}, adj[30:15]};
    faster = (!c18[17] && (t18 > c18)) || ((c18[17] || (c18 == 18'sd0)) && (t18 < c18));
    s18    = $signed({2'b00, (faster ? up_r : down_r)});
    n_up   = c18 + s18;
    n_dn   = c18 - s18;
    if (t18 > c18) begin
      moved = (n_up < t18) ? n_up : t18;
    end else begin
      moved = (n_dn > t18) ? n_dn : t18;
    end
  end

  // Clamp the wheel power, zero it when disabled, invert the back wheels
  always_comb begin
    q10   = adj[24:15];
    lim10 = $signed({3'b000, max_speed_r});
    priority if (q10 > lim10) begin
      clamped = lim10;
    end else if (q10 < -lim10) begin
      clamped = -lim10;
    end else begin
      clamped = q10;
    end
    gated = en_r ? clamped : 10'sd0;
    pk    = cnt_r[1] ? gated : -gated;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= MAX_SPEED_RST;
      ramp_up_r   <= RAMP_UP_RST;
      ramp_down_r <= RAMP_DOWN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_SPEED: max_speed_r <= cfg_data[6:0];
        CFG_RAMP_UP:   ramp_up_r   <= cfg_data;
        CFG_RAMP_DOWN: ramp_down_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and ramped axis state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      phase_r   <= 1'b0;
      div_sel_r <= 1'b0;
      axes_r[0] <= '0;
      axes_r[1] <= '0;
      axes_r[2] <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r   <= S_DIV;
            div_sel_r <= 1'b0;
            // Disabled tick ramps from zero
            if (!in_tuser) begin
              axes_r[0] <= '0;
              axes_r[1] <= '0;
              axes_r[2] <= '0;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!div_sel_r) begin
              div_sel_r <= 1'b1;
            end else begin
              state_r <= S_AXIS;
              cnt_r   <= '0;
              phase_r <= 1'b0;
            end
          end
        end
        S_AXIS: begin
          phase_r <= !phase_r;
          if (phase_r) begin
            axes_r[cnt_r] <= moved[15:0];
            if (cnt_r == 2'd2) begin
              state_r <= S_WHEEL;
              cnt_r   <= '0;
            end else begin
              cnt_r <= cnt_r + 2'd1;
            end
          end
        end
        S_WHEEL: begin
          phase_r <= !phase_r;
          if (phase_r) begin
            cnt_r <= cnt_r + 2'd1;
            if (cnt_r == 2'd3) begin
              state_r <= S_HAND;
            end
          end
        end
        S_HAND: begin
          if (ser_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Request payload, ramp steps, products and packet powers
  always_ff @(posedge clk) begin
    if (accept) begin
      axin_r[0] <= $signed(in_tdata[15:0]);
      axin_r[1] <= $signed(in_tdata[31:16]);
      axin_r[2] <= $signed(in_tdata[47:32]);
      speed_r   <= in_tdata[62:48];
      elapsed_r <= in_tdata[78:63];
      en_r      <= in_tuser;
    end
    if ((state_r == S_DIV) && div_done) begin
      if (!div_sel_r) begin
        up_r <= div_quot;
      end else begin
        down_r <= div_quot;
      end
    end
    if (!phase_r) begin
      prod_r <= prod;
    end
    if ((state_r == S_WHEEL) && phase_r) begin
      pwr_r[cnt_r] <= pk[7:0];
    end
  end

  // Hand the four powers to the serializer
  assign ser_req.load  = (state_r == S_HAND) && ser_ready;
  assign ser_req.power = pwr_r;

  odrmp_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (ser_req),
    .ready      (ser_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== src/odrmp_chk.sv =====
// Port-level checker for the drive mixer, bound to the top level.
// Uses the assertion macros from omni_drive_ramp_mix_packetizer_defines.svh.
`include "omni_drive_ramp_mix_packetizer_defines.svh"

module odrmp_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       cfg_ready
);

  // Hold a stalled byte
  `ODRMP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output byte changed")

  // Drop ready once a request is taken
  `ODRMP_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "input ready right after a request")

  // Checksum closes the run and has bit seven clear
  `ODRMP_ASSERT_SAME(a_last_is_checksum, out_tvalid && out_tlast, !out_tdata[7], "last byte is not a checksum")

  // Config port never stalls
  `ODRMP_ASSERT_SAME(a_cfg_ready, 1'b1, cfg_ready, "config port stalled")

endmodule

bind omni_drive_ramp_mix_packetizer odrmp_chk u_odrmp_chk (.*);
